// ===== rtl/madl_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Multichannel axon delay line package
// Field widths, stream word layouts and the operation and status codes that
// the delay line shares with its users.
// ---------------------------------------------------------------------------
package madl_pkg;

   localparam int CHANNEL_W   = 6;
   localparam int DELAY_W     = 8;
   localparam int DATA_W      = 32;
   localparam int STATUS_W    = 2;

   // Request tdata: channel, delay, activity, padded to whole bytes.
   localparam int REQ_TDATA_W = 48;
   // Response tdata: tapped_value, status, padded to whole bytes.
   localparam int RSP_TDATA_W = 40;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_TAP  = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 2'd0,
      ST_BAD_CHANNEL = 2'd1,
      ST_BAD_DELAY   = 2'd2
   } status_type;

endpackage

// ===== rtl/multichannel_axon_delay_line.sv =====
`timescale 1ns / 1ps
// Pipeline: stage one, then the response register for tap results.
// Throughput: one transaction per cycle, pushes and taps mixed freely, unless
//   a tap waits on rsp_tready; forwarding closes the write-position RMW loop.
// Reset: synchronous; afterwards the write-position memory is cleared
//   with req_tready low. The history memory is never cleared:
//   a per-channel wrap flag tells which ring slots were written.
// ---------------------------------------------------------------------------
// Multichannel axon delay line
// A bank of per-channel ring buffers held in one memory. Push transactions
// store a channel's newest activity word; tap transactions return the word
// pushed a given number of pushes before the newest one.
// ---------------------------------------------------------------------------
module multichannel_axon_delay_line #(
   parameter int CHANNELS  = 64,
   parameter int MAX_DELAY = 255
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [5:0] channel, [13:6] delay, [45:14] activity, [47:46] zero
   input  logic [madl_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [0] opcode
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [31:0] tapped_value, [33:32] status, [39:34] zero
   output logic [madl_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int RING_SLOTS  = MAX_DELAY + 1;
   localparam int SLOT_W      = $clog2(RING_SLOTS);
   localparam int META_W      = SLOT_W + 1;
   localparam int CIDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int STORE_DEPTH = CHANNELS * RING_SLOTS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int T_W         =
      ((SLOT_W + 1 > madl_pkg::DELAY_W) ? SLOT_W + 1 : madl_pkg::DELAY_W) + 1;

   // Per-channel ring state: {wrapped, write position}.
   logic [META_W-1:0]             meta_mem [CHANNELS];
   logic [madl_pkg::DATA_W-1:0]   store_mem [STORE_DEPTH];

   logic                          clearing_ff;
   logic [CIDX_W-1:0]             clr_cnt_ff;

   logic                          s1_valid_ff;
   madl_pkg::opcode_type          s1_op_ff;
   logic [madl_pkg::CHANNEL_W-1:0] s1_ch_ff;
   logic [madl_pkg::DELAY_W-1:0]  s1_delay_ff;
   logic [madl_pkg::DATA_W-1:0]   s1_act_ff;
   logic [META_W-1:0]             meta_rd_ff;
   logic                          fwd_hit_ff;
   logic [META_W-1:0]             fwd_meta_ff;

   logic                          rsp_valid_ff;
   madl_pkg::status_type          rsp_status_ff;
   logic                          rsp_zero_ff;
   logic [madl_pkg::DATA_W-1:0]   store_rd_ff;

   logic                          req_accept;
   logic [madl_pkg::CHANNEL_W-1:0] req_ch;
   logic [madl_pkg::DELAY_W-1:0]  req_delay;
   logic [madl_pkg::DATA_W-1:0]   req_act;
   logic [CIDX_W-1:0]             req_idx;
   logic [CIDX_W-1:0]             s1_idx;

   logic [META_W-1:0]             meta_cur;
   logic [SLOT_W-1:0]             wp;
   logic                          wrapped;
   logic [META_W-1:0]             wp_inc;
   logic [META_W-1:0]             meta_next;
   logic                          ch_bad;
   logic                          dl_bad;
   logic                          written;
   logic [T_W-1:0]                slot_sum;
   logic [T_W-1:0]                slot_wide;
   logic [SLOT_W-1:0]             tap_slot;
   logic [SLOT_W-1:0]             slot;
   logic [ADDR_W-1:0]             store_addr;
   logic                          out_free;
   logic                          push_ok;
   logic                          s1_tap;
   logic                          s1_advance;
   logic                          tap_read;
   madl_pkg::status_type          status_in;

   assign req_ch     = req_tdata[5:0];
   assign req_delay  = req_tdata[13:6];
   assign req_act    = req_tdata[45:14];
   assign req_idx    = CIDX_W'(req_ch);
   assign s1_idx     = CIDX_W'(s1_ch_ff);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_tap     = s1_valid_ff && (s1_op_ff == madl_pkg::OP_TAP);
   assign s1_advance = s1_valid_ff && ((s1_op_ff == madl_pkg::OP_PUSH) || out_free);
   assign req_tready = !clearing_ff && (!s1_valid_ff || s1_advance);
   assign req_accept = req_tvalid && req_tready;

   // A push that leaves stage one as the next transaction enters overlaps
   // the memory write, so its updated ring state is forwarded.
   assign meta_cur = fwd_hit_ff ? fwd_meta_ff : meta_rd_ff;
   assign wp       = meta_cur[SLOT_W-1:0];
   assign wrapped  = meta_cur[SLOT_W];

   assign ch_bad   = 32'(s1_ch_ff) >= CHANNELS;
   assign dl_bad   = (s1_delay_ff == '0) || (32'(s1_delay_ff) > MAX_DELAY);
   assign push_ok  = s1_valid_ff && (s1_op_ff == madl_pkg::OP_PUSH) && !ch_bad;

   assign wp_inc    = META_W'(wp) + META_W'(1);
   assign meta_next = (wp_inc == META_W'(RING_SLOTS)) ? {1'b1, {SLOT_W{1'b0}}}
                                                      : {wrapped, wp_inc[SLOT_W-1:0]};

   // Slot of the word pushed delay pushes before the newest one.
   assign slot_sum  = T_W'(wp) + T_W'(RING_SLOTS) - T_W'(1) - T_W'(s1_delay_ff);
   assign slot_wide = (slot_sum >= T_W'(RING_SLOTS)) ? slot_sum - T_W'(RING_SLOTS)
                                                     : slot_sum;
   assign tap_slot  = slot_wide[SLOT_W-1:0];
   // Before a ring wraps, only slots below the write position hold pushes.
   assign written   = wrapped || (T_W'(s1_delay_ff) < T_W'(wp));

   assign slot       = (s1_op_ff == madl_pkg::OP_PUSH) ? wp : tap_slot;
   assign store_addr = ADDR_W'(s1_idx) * ADDR_W'(RING_SLOTS) + ADDR_W'(slot);

   assign tap_read  = s1_tap && out_free && !ch_bad && !dl_bad && written;

   always_comb begin
      if (ch_bad) begin
         status_in = madl_pkg::ST_BAD_CHANNEL;
      end else if (dl_bad) begin
         status_in = madl_pkg::ST_BAD_DELAY;
      end else begin
         status_in = madl_pkg::ST_OK;
      end
   end

   // Clearing pass over the write-position memory after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         if (clr_cnt_ff == CIDX_W'(CHANNELS - 1)) begin
            clearing_ff <= 1'b0;
         end else begin
            clr_cnt_ff <= clr_cnt_ff + CIDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         meta_mem[clr_cnt_ff] <= '0;
      end else if (push_ok) begin
         meta_mem[s1_idx] <= meta_next;
      end
      if (req_accept) begin
         meta_rd_ff <= meta_mem[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         store_mem[store_addr] <= s1_act_ff;
      end
      if (tap_read) begin
         store_rd_ff <= store_mem[store_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff    <= madl_pkg::opcode_type'(req_tuser);
         s1_ch_ff    <= req_ch;
         s1_delay_ff <= req_delay;
         s1_act_ff   <= req_act;
         fwd_hit_ff  <= push_ok && (s1_ch_ff == req_ch);
         fwd_meta_ff <= meta_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_tap && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_tap && out_free) begin
         rsp_status_ff <= status_in;
         rsp_zero_ff   <= !tap_read;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff,
                        rsp_zero_ff ? {madl_pkg::DATA_W{1'b0}} : store_rd_ff};

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Multichannel axon delay line testbench
// Drives push and tap transactions into the delay line and keeps its own copy
// of every channel's ring and write position. Each tap result is compared
// with the value and status that the copy predicts, in order. Directed
// transactions cover empty history, the delay extremes and the bad-delay
// status. Random traffic then concentrates on a few channels, so that the busiest
// channel's ring wraps. Both stream sides stall at random.
// ---------------------------------------------------------------------------
module testbench;

   localparam int CHANNELS     = 64;
   localparam int MAX_DELAY    = 255;
   localparam int RING_SLOTS   = MAX_DELAY + 1;
   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 460;
   localparam int DEEP_CHANNEL = 37;

   typedef logic [madl_pkg::CHANNEL_W-1:0] channel_type;
   typedef logic [madl_pkg::DELAY_W-1:0]   delay_type;
   typedef logic [madl_pkg::DATA_W-1:0]    data_type;

   typedef struct {
      data_type             value;
      madl_pkg::status_type status;
   } tap_result_type;

   class tap_scoreboard;
      data_type       history [CHANNELS*RING_SLOTS];
      int             head [CHANNELS];
      tap_result_type pending [$];
      int             failures;

      function new();
         foreach (history[i]) history[i] = '0;
         foreach (head[i]) head[i] = 0;
         failures = 0;
      endfunction

      function int outstanding();
         return pending.size();
      endfunction

      // Updates the ring copy for a push and queues the expected tap result.
      function void note_request(madl_pkg::opcode_type op, channel_type ch,
                                 delay_type dl, data_type act);
         tap_result_type r;
         int             slot;
         if (op == madl_pkg::OP_PUSH) begin
            if (int'(ch) >= CHANNELS)
               return;
            history[int'(ch)*RING_SLOTS + head[ch]] = act;
            head[ch] = (head[ch] + 1) % RING_SLOTS;
            return;
         end
         r.value = '0;
         if (int'(ch) >= CHANNELS) begin
            r.status = madl_pkg::ST_BAD_CHANNEL;
         end else if (dl < 1 || int'(dl) > MAX_DELAY) begin
            r.status = madl_pkg::ST_BAD_DELAY;
         end else begin
            // The newest word sits one slot behind the write position.
            slot     = (head[ch] + RING_SLOTS - 1 - int'(dl)) % RING_SLOTS;
            r.value  = history[int'(ch)*RING_SLOTS + slot];
            r.status = madl_pkg::ST_OK;
         end
         pending.push_back(r);
      endfunction

      function void check_response(logic [madl_pkg::RSP_TDATA_W-1:0] tdata);
         tap_result_type r;
         if (pending.size() == 0) begin
            $error("tap result %h arrived with none outstanding", tdata);
            failures++;
            return;
         end
         r = pending.pop_front();
         if (tdata[madl_pkg::DATA_W-1:0] !== r.value) begin
            $error("tapped_value: expected %h, actual %h", r.value,
                   tdata[madl_pkg::DATA_W-1:0]);
            failures++;
         end
         if (tdata[madl_pkg::DATA_W +: madl_pkg::STATUS_W] !== r.status) begin
            $error("status: expected %0d, actual %0d", r.status,
                   tdata[madl_pkg::DATA_W +: madl_pkg::STATUS_W]);
            failures++;
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   // [5:0] channel, [13:6] delay, [45:14] activity, [47:46] zero
   logic [madl_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   // [0] opcode
   logic                             req_tuser = madl_pkg::OP_PUSH;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // [31:0] tapped_value, [33:32] status, [39:34] zero
   logic [madl_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   tap_scoreboard sb = new();
   int            send_idle_pct = 15;
   int            recv_idle_pct = 64;
   int            stall_cycles = 0;

   multichannel_axon_delay_line #(
      .CHANNELS  (CHANNELS),
      .MAX_DELAY (MAX_DELAY)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Result side: check each accepted transaction, then pick the next ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Counts cycles without progress while work is still waiting.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          !(req_tvalid || sb.outstanding() != 0)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_request(input madl_pkg::opcode_type op, input channel_type ch,
                               input delay_type dl, input data_type act);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, act, dl, ch};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sb.note_request(op, ch, dl, act);
   endtask

   // Half the traffic lands on one channel so that its ring wraps; a quarter
   // goes to a few other busy channels and the rest anywhere.
   task automatic send_random_request();
      int                   pick;
      madl_pkg::opcode_type op;
      channel_type          ch;
      delay_type            dl;
      pick = $urandom_range(99);
      if (pick < 50)
         ch = channel_type'(DEEP_CHANNEL);
      else if (pick < 75)
         ch = (pick[1:0] == 2'd0) ? 6'd0 : (pick[1:0] == 2'd1) ? 6'd63 :
              (pick[1:0] == 2'd2) ? 6'd21 : 6'd42;
      else
         ch = channel_type'($urandom);
      op = ($urandom_range(99) < 60) ? madl_pkg::OP_PUSH : madl_pkg::OP_TAP;
      pick = $urandom_range(99);
      if (pick < 8)
         dl = '0;
      else if (pick < 16)
         dl = delay_type'(MAX_DELAY);
      else if (pick < 50)
         dl = delay_type'($urandom_range(8, 1));
      else
         dl = delay_type'($urandom_range(MAX_DELAY, 1));
      send_request(op, ch, dl, $urandom);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty history reads zero; delay zero is rejected.
      send_request(madl_pkg::OP_TAP,  6'd0,  8'd1,   32'h0000_0000);
      send_request(madl_pkg::OP_TAP,  6'd63, 8'd255, 32'h0000_0000);
      send_request(madl_pkg::OP_TAP,  6'd5,  8'd0,   32'hFFFF_FFFF);
      send_request(madl_pkg::OP_PUSH, 6'd0,  8'd0,   32'hFFFF_FFFF);
      send_request(madl_pkg::OP_PUSH, 6'd0,  8'd0,   32'h0000_0000);
      send_request(madl_pkg::OP_PUSH, 6'd0,  8'd0,   32'hA5A5_A5A5);
      send_request(madl_pkg::OP_TAP,  6'd0,  8'd1,   32'h0000_0000);
      send_request(madl_pkg::OP_TAP,  6'd0,  8'd2,   32'h0000_0000);
      send_request(madl_pkg::OP_TAP,  6'd0,  8'd3,   32'h0000_0000);
      send_request(madl_pkg::OP_TAP,  6'd0,  8'd255, 32'h0000_0000);
      send_request(madl_pkg::OP_PUSH, 6'd63, 8'd0,   32'h5A5A_5A5A);
      send_request(madl_pkg::OP_PUSH, 6'd63, 8'd255, 32'hFFFF_FFFF);
      send_request(madl_pkg::OP_TAP,  6'd63, 8'd1,   32'h0000_0000);
      send_request(madl_pkg::OP_TAP,  6'd63, 8'd0,   32'h0000_0000);
      // The delay field of a push and the activity field of a tap are ignored.
      send_request(madl_pkg::OP_PUSH, 6'd0,  8'd255, 32'h1234_5678);
      send_request(madl_pkg::OP_TAP,  6'd0,  8'd1,   32'hFFFF_FFFF);
      send_request(madl_pkg::OP_TAP,  6'd63, 8'd255, 32'hFFFF_FFFF);

      repeat (PHASE_ITEMS) send_random_request();
      send_idle_pct = 64;
      recv_idle_pct = 15;
      repeat (PHASE_ITEMS) send_random_request();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (PHASE_ITEMS) send_random_request();
      req_tvalid <= 1'b0;

      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
